>>> src/rlt_pkg.sv
// ----------------------------------------------------------------------------
// rlt_pkg: shared types and codes for the range lock table
//
// Holds the table entry layout, the per-entry compare flags, the request
// action and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package rlt_pkg;

    localparam int CLIENT_W = 32;
    localparam int ID_W     = 31;
    localparam int ADDR_W   = 48;

    // Request actions
    localparam logic [1:0] ACT_REGISTER   = 2'd0;
    localparam logic [1:0] ACT_UNREGISTER = 2'd1;
    localparam logic [1:0] ACT_DISCONNECT = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_COLLIDE   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // One held range; the request is kept in the same layout
    typedef struct packed {
        logic [CLIENT_W-1:0] client;
        logic [ID_W-1:0]     id;
        logic [ADDR_W-1:0]   start;
        logic [ADDR_W-1:0]   length;
        logic                write;
    } entry_t;

    // Flags from comparing the request against one entry
    typedef struct packed {
        logic clash;
        logic exact;
        logic same_client;
    } cmp_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_SCAN,
        SEQ_FINISH
    } seq_state_t;

endpackage

>>> src/rlt_entry_ram.sv
// ----------------------------------------------------------------------------
// rlt_entry_ram: storage for the held ranges
//
// One write port and one read port with registered read data. Contents are
// undefined until written; occupancy is tracked outside in flip-flops.
// ----------------------------------------------------------------------------
module rlt_entry_ram #(
    parameter int DEPTH  = 16,
    parameter int INDEX_W = 4
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [INDEX_W-1:0]   wr_addr,
    input  rlt_pkg::entry_t      wr_data,
    input  logic                 rd_en,
    input  logic [INDEX_W-1:0]   rd_addr,
    output rlt_pkg::entry_t      rd_data
);
    import rlt_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // Write a new entry
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one entry per cycle
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/rlt_cmp_unit.sv
// ----------------------------------------------------------------------------
// rlt_cmp_unit: shared compare unit
//
// Compares the current request against one stored entry: range overlap with
// reader/writer rule, exact match for unregister, and client match.
// ----------------------------------------------------------------------------
module rlt_cmp_unit (
    input  rlt_pkg::entry_t req,
    input  rlt_pkg::entry_t ent,
    output rlt_pkg::cmp_t   flags
);
    import rlt_pkg::*;

    logic [ADDR_W:0] req_end;
    logic [ADDR_W:0] ent_end;
    logic            overlap;

    // Form range ends one bit wider so they never wrap
    assign req_end = {1'b0, req.start} + {1'b0, req.length};
    assign ent_end = {1'b0, ent.start} + {1'b0, ent.length};

    // Either start lies inside the other range
    assign overlap = ((req.start >= ent.start) && ({1'b0, req.start} < ent_end)) ||
                     ((ent.start >= req.start) && ({1'b0, ent.start} < req_end));

    assign flags.clash       = overlap && ((req.write != ent.write) || ent.write);
    assign flags.exact       = (req == ent);
    assign flags.same_client = (req.client == ent.client);

endmodule

>>> src/range_lock_table.sv
// ----------------------------------------------------------------------------
// range_lock_table: reader/writer byte range lock table
//
// Keeps up to TABLE_ENTRIES held ranges and answers register, unregister and
// disconnect requests with one status word each.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one request word (action, client, range id, offset,
//   size, mode). The m_ channel returns one result word (status, granted id)
//   per request. Both use valid/ready.
//   Each request walks every table entry through one shared compare unit,
//   one entry per cycle, fed by the entry memory's single read port with a
//   registered read. s_ready is low from accept until the result is committed,
//   so one request is in flight at a time.
//   A new request is accepted while the previous result still waits on m_.
//   If the receiver stalls, the finished request holds in its last step until
//   the result register is free; a register updates the table when the result
//   loads, while unregister and disconnect clear entries during the walk.
//   Reset (aresetn low, synchronous) empties the table, sets the next
//   granted id to 1 and drops any pending result. No clearing pass is needed.
// ----------------------------------------------------------------------------
module range_lock_table #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // request channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_action,
    input  logic [rlt_pkg::CLIENT_W-1:0]   s_client_id,
    input  logic [rlt_pkg::ID_W-1:0]       s_range_id,
    input  logic [rlt_pkg::ADDR_W-1:0]     s_range_offset,
    input  logic [rlt_pkg::ADDR_W-1:0]     s_range_size,
    input  logic                           s_write_mode,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_status,
    output logic [rlt_pkg::ID_W-1:0]       m_granted_id
);
    import rlt_pkg::*;

    localparam int INDEX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES);

    // sequencer and control
    seq_state_t                state_reg, state_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      pend_reg, pend_next;
    logic [INDEX_W-1:0]        pidx_reg, pidx_next;
    logic [TABLE_ENTRIES-1:0]  valid_reg, valid_next;
    logic                      clash_reg, clash_next;
    logic                      free_found_reg, free_found_next;
    logic [INDEX_W-1:0]        free_idx_reg, free_idx_next;
    logic                      hit_reg, hit_next;
    logic [ID_W-1:0]           next_id_reg, next_id_next;
    logic                      m_valid_reg, m_valid_next;

    // payload
    entry_t                    req_reg, req_next;
    logic [1:0]                act_reg, act_next;
    logic [1:0]                m_status_reg, m_status_next;
    logic [ID_W-1:0]           m_granted_reg, m_granted_next;

    // memory and compare unit hookup
    logic                      ram_wr_en;
    entry_t                    ram_wr_data;
    logic                      ram_rd_en;
    logic [INDEX_W-1:0]        ram_rd_addr;
    entry_t                    ram_rd_data;
    cmp_t                      cmp_flags;
    logic                      scan_more;

    rlt_entry_ram #(
        .DEPTH   (TABLE_ENTRIES),
        .INDEX_W (INDEX_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (free_idx_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    rlt_cmp_unit u_cmp (
        .req   (req_reg),
        .ent   (ram_rd_data),
        .flags (cmp_flags)
    );

    assign scan_more   = (cnt_reg < CNT_LAST);
    assign ram_rd_addr = cnt_reg[INDEX_W-1:0];

    // Store the request under the id it is granted
    always_comb begin
        ram_wr_data    = req_reg;
        ram_wr_data.id = next_id_reg;
    end

    // Next state, table update and result
    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        pidx_next       = pidx_reg;
        valid_next      = valid_reg;
        clash_next      = clash_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        hit_next        = hit_reg;
        next_id_next    = next_id_reg;
        req_next        = req_reg;
        act_next        = act_reg;
        m_status_next   = m_status_reg;
        m_granted_next  = m_granted_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        ram_wr_en       = 1'b0;
        ram_rd_en       = 1'b0;

        unique case (state_reg)
            SEQ_IDLE: begin
                // Take a request word and start a walk at entry 0
                if (s_valid) begin
                    req_next.client = s_client_id;
                    req_next.id     = s_range_id;
                    req_next.start  = s_range_offset;
                    req_next.length = s_range_size;
                    req_next.write  = s_write_mode;
                    act_next        = s_action;
                    cnt_next        = '0;
                    pend_next       = 1'b0;
                    clash_next      = 1'b0;
                    free_found_next = 1'b0;
                    hit_next        = 1'b0;
                    state_next      = SEQ_SCAN;
                end
            end

            SEQ_SCAN: begin
                // Issue the next read
                ram_rd_en = scan_more;
                pend_next = scan_more;
                pidx_next = cnt_reg[INDEX_W-1:0];
                if (scan_more) begin
                    cnt_next = cnt_reg + 1'b1;
                end

                // Evaluate the entry read last cycle
                if (pend_reg) begin
                    if (valid_reg[pidx_reg]) begin
                        priority if (act_reg == ACT_REGISTER) begin
                            if (cmp_flags.clash) begin
                                clash_next = 1'b1;
                            end
                        end else if (act_reg == ACT_UNREGISTER) begin
                            if (cmp_flags.exact && !hit_reg) begin
                                hit_next             = 1'b1;
                                valid_next[pidx_reg] = 1'b0;
                            end
                        end else if (act_reg == ACT_DISCONNECT) begin
                            if (cmp_flags.same_client) begin
                                valid_next[pidx_reg] = 1'b0;
                            end
                        end else begin
                            // unused action: leave the table alone
                        end
                    end else if (!free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = pidx_reg;
                    end
                end

                if (!scan_more && !pend_reg) begin
                    state_next = SEQ_FINISH;
                end
            end

            SEQ_FINISH: begin
                // Hold until the result register is free, then commit
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_granted_next = '0;
                    priority if (act_reg == ACT_REGISTER) begin
                        priority if (clash_reg) begin
                            m_status_next = ST_COLLIDE;
                        end else if (!free_found_reg) begin
                            m_status_next = ST_FULL;
                        end else begin
                            m_status_next           = ST_OK;
                            m_granted_next          = next_id_reg;
                            ram_wr_en               = 1'b1;
                            valid_next[free_idx_reg] = 1'b1;
                            next_id_next = (next_id_reg == {ID_W{1'b1}}) ?
                                           ID_W'(1) : next_id_reg + 1'b1;
                        end
                    end else if (act_reg == ACT_UNREGISTER) begin
                        m_status_next = hit_reg ? ST_OK : ST_NOT_FOUND;
                    end else if (act_reg == ACT_DISCONNECT) begin
                        m_status_next = ST_OK;
                    end else begin
                        m_status_next = ST_NOT_FOUND;
                    end
                    state_next = SEQ_IDLE;
                end
            end

            default: begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= SEQ_IDLE;
            cnt_reg        <= '0;
            pend_reg       <= 1'b0;
            valid_reg      <= '0;
            clash_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            hit_reg        <= 1'b0;
            next_id_reg    <= ID_W'(1);
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pend_reg       <= pend_next;
            valid_reg      <= valid_next;
            clash_reg      <= clash_next;
            free_found_reg <= free_found_next;
            hit_reg        <= hit_next;
            next_id_reg    <= next_id_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        pidx_reg      <= pidx_next;
        free_idx_reg  <= free_idx_next;
        req_reg       <= req_next;
        act_reg       <= act_next;
        m_status_reg  <= m_status_next;
        m_granted_reg <= m_granted_next;
    end

    assign s_ready      = (state_reg == SEQ_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_granted_id = m_granted_reg;

    // A result word only appears after the commit step
    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == SEQ_FINISH))
        else $error("result word without commit step");

    // A result that is not OK carries no id
    a_granted_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ST_OK)) |-> (m_granted_id == '0))
        else $error("id given on a refused or non-register request");

    // The id counter never hands out zero
    a_id_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        next_id_reg != '0)
        else $error("range id counter reached zero");

    // A full answer means no slot was free during the walk
    a_full_no_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) && (m_status == ST_FULL) |-> $past(!free_found_reg))
        else $error("table full reported with a free slot");

endmodule

>>> verif/range_lock_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// range_lock_table_test: self-checking bench for the range lock table
//
// Drives register, unregister, disconnect and unused-action requests on s_.
// A shadow copy of the lock table predicts the status word and granted id of
// each accepted request. Every m_ word is checked against those predictions
// in order. The stimulus is a short directed pass, then random traffic
// whose unregisters mostly replay held ranges; input bursts, receiver stalls.
// ----------------------------------------------------------------------------
module range_lock_table_test;
    import rlt_pkg::*;

    localparam int          DEPTH         = 16;
    localparam int          RANDOM_ITEMS  = 525;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          DRAIN_CYCLES  = DEPTH + 3 + 20;
    localparam int          HOLD_AT       = 40;
    localparam int          HOLD_CYCLES   = 300;
    localparam logic [1:0]  ACT_UNUSED    = 2'd3;
    localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

    typedef struct packed {
        logic [1:0] action;
        entry_t     body;
    } req_t;

    typedef struct packed {
        logic [1:0]      status;
        logic [ID_W-1:0] granted;
    } reply_t;

    // ------------------------------------------------------------------------
    // Shadow lock table: predicts each reply and checks the block's words
    // ------------------------------------------------------------------------
    class lock_table_shadow;
        entry_t          held[DEPTH];
        bit              held_valid[DEPTH];
        logic [ID_W-1:0] next_id;
        reply_t          pending_replies[$];
        int              failures;

        function new();
            foreach (held_valid[i]) held_valid[i] = 1'b0;
            next_id  = 1;
            failures = 0;
        endfunction

        // Overlap test with sums one bit wider than the offsets
        function bit spans_meet(logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] la,
                                logic [ADDR_W-1:0] b, logic [ADDR_W-1:0] lb);
            logic [ADDR_W:0] end_a;
            logic [ADDR_W:0] end_b;
            end_a = {1'b0, a} + {1'b0, la};
            end_b = {1'b0, b} + {1'b0, lb};
            return (a >= b && {1'b0, a} < end_b) || (b >= a && {1'b0, b} < end_a);
        endfunction

        // Apply one accepted request and queue its reply
        function void note_request(req_t r);
            reply_t rep;
            bit     clash;
            int     free_slot;
            rep.status  = ST_NOT_FOUND;
            rep.granted = '0;
            case (r.action)
                ACT_REGISTER: begin
                    clash     = 1'b0;
                    free_slot = -1;
                    for (int i = 0; i < DEPTH; i++) begin
                        if (held_valid[i]) begin
                            if (spans_meet(r.body.start, r.body.length,
                                           held[i].start, held[i].length) &&
                                (r.body.write != held[i].write || held[i].write))
                                clash = 1'b1;
                        end else if (free_slot < 0) begin
                            free_slot = i;
                        end
                    end
                    if (clash) begin
                        rep.status = ST_COLLIDE;
                    end else if (free_slot < 0) begin
                        rep.status = ST_FULL;
                    end else begin
                        held[free_slot]       = r.body;
                        held[free_slot].id    = next_id;
                        held_valid[free_slot] = 1'b1;
                        rep.status            = ST_OK;
                        rep.granted           = next_id;
                        next_id = (next_id == '1) ? ID_W'(1) : next_id + 1'b1;
                    end
                end
                ACT_UNREGISTER: begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (held_valid[i] && held[i] == r.body) begin
                            held_valid[i] = 1'b0;
                            rep.status    = ST_OK;
                            break;
                        end
                    end
                end
                ACT_DISCONNECT: begin
                    for (int i = 0; i < DEPTH; i++)
                        if (held_valid[i] && held[i].client == r.body.client)
                            held_valid[i] = 1'b0;
                    rep.status = ST_OK;
                end
                default: ;
            endcase
            pending_replies.insert(pending_replies.size(), rep);
        endfunction

        // Compare one accepted result word with the oldest prediction
        function void check_reply(logic [1:0] status, logic [ID_W-1:0] granted);
            reply_t exp_rep;
            if (pending_replies.size() == 0) begin
                $error("result word with no request pending: status %0d granted_id %0d",
                       status, granted);
                failures++;
                return;
            end
            exp_rep = pending_replies.pop_front();
            if (status !== exp_rep.status) begin
                $error("status: expected %0d, got %0d", exp_rep.status, status);
                failures++;
            end
            if (granted !== exp_rep.granted) begin
                $error("granted_id: expected %0d, got %0d", exp_rep.granted, granted);
                failures++;
            end
        endfunction

        function int outstanding();
            return pending_replies.size();
        endfunction

        // Pick one held range at random; returns 0 when the table is empty
        function bit pick_held(output entry_t e);
            int live[$];
            e = '0;
            for (int i = 0; i < DEPTH; i++)
                if (held_valid[i]) live.insert(live.size(), i);
            if (live.size() == 0) return 1'b0;
            e = held[live[$urandom_range(0, live.size() - 1)]];
            return 1'b1;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and ports
    // ------------------------------------------------------------------------
    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic [1:0]         s_action       = ACT_REGISTER;
    logic [CLIENT_W-1:0] s_client_id   = '0;
    logic [ID_W-1:0]    s_range_id     = '0;
    logic [ADDR_W-1:0]  s_range_offset = '0;
    logic [ADDR_W-1:0]  s_range_size   = '0;
    logic               s_write_mode   = 1'b0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic [1:0]         m_status;
    logic [ID_W-1:0]    m_granted_id;

    lock_table_shadow   shadow = new();
    int                 cycle_count   = 0;
    int                 replies_seen  = 0;
    int                 hold_left     = 0;
    bit                 hold_done     = 1'b0;
    int                 stall_mode    = 0;
    int                 mode_left     = 0;
    int                 stall_phase   = 0;

    logic [CLIENT_W-1:0] client_pool[4] = '{32'h0000_0001, 32'h8000_0002,
                                            32'h7FFF_FFFF, 32'hFFFF_FFFE};

    always #5 aclk = ~aclk;

    range_lock_table #(.TABLE_ENTRIES(DEPTH)) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_client_id    (s_client_id),
        .s_range_id     (s_range_id),
        .s_range_offset (s_range_offset),
        .s_range_size   (s_range_size),
        .s_write_mode   (s_write_mode),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_granted_id   (m_granted_id)
    );

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: check accepted words, stall on changing patterns, and hold
    // off once for a long stretch so the block backs up
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            shadow.check_reply(m_status, m_granted_id);
            replies_seen++;
        end
        stall_phase++;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_done && replies_seen == HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(50, 300);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= $urandom_range(0, 1);
                2:       m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= ((stall_phase % 24) < 7);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------------

    // Offer one word and hold it until accepted, then predict its reply
    task automatic send_request(input req_t r);
        s_valid        <= 1'b1;
        s_action       <= r.action;
        s_client_id    <= r.body.client;
        s_range_id     <= r.body.id;
        s_range_offset <= r.body.start;
        s_range_size   <= r.body.length;
        s_write_mode   <= r.body.write;
        do @(posedge aclk); while (s_ready !== 1'b1);
        shadow.note_request(r);
    endtask

    task automatic idle_cycles(input int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // Drop valid and wait until every predicted reply has come back
    task automatic drain_replies();
        s_valid <= 1'b0;
        do @(posedge aclk); while (shadow.outstanding() > 0);
    endtask

    task automatic issue(input logic [1:0] action, input logic [CLIENT_W-1:0] client,
                         input logic [ID_W-1:0] rid, input logic [ADDR_W-1:0] offset,
                         input logic [ADDR_W-1:0] size, input logic write);
        req_t r;
        r.action      = action;
        r.body.client = client;
        r.body.id     = rid;
        r.body.start  = offset;
        r.body.length = size;
        r.body.write  = write;
        send_request(r);
    endtask

    function automatic logic [ADDR_W-1:0] wide_random();
        return ADDR_W'({$urandom(), $urandom()});
    endfunction

    function automatic logic [CLIENT_W-1:0] random_client();
        if ($urandom_range(0, 9) == 0) return $urandom();
        return client_pool[$urandom_range(0, 3)];
    endfunction

    // Offsets mostly fall in a small window so ranges overlap often
    function automatic logic [ADDR_W-1:0] random_offset();
        case ($urandom_range(0, 9))
            8:       return ADDR_MAX - ADDR_W'($urandom_range(0, 255));
            9:       return wide_random();
            default: return ADDR_W'($urandom_range(0, 511));
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] random_size();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return wide_random();
            2:       return ADDR_MAX - ADDR_W'($urandom_range(0, 255));
            default: return ADDR_W'($urandom_range(1, 64));
        endcase
    endfunction

    // Build one random request; unregisters mostly replay a held range
    task automatic make_random_request(output req_t r);
        entry_t held_one;
        int     pick;
        pick          = $urandom_range(0, 99);
        r.body.client = random_client();
        r.body.id     = ID_W'($urandom());
        r.body.start  = random_offset();
        r.body.length = random_size();
        r.body.write  = ($urandom_range(0, 9) < 3);
        if (pick < 45) begin
            r.action = ACT_REGISTER;
        end else if (pick < 82) begin
            r.action = ACT_UNREGISTER;
            if (shadow.pick_held(held_one) && $urandom_range(0, 9) != 0) begin
                r.body = held_one;
                case ($urandom_range(0, 7))
                    0:       r.body.id     = held_one.id ^ (ID_W'(1) << $urandom_range(0, ID_W - 1));
                    1:       r.body.write  = ~held_one.write;
                    2:       r.body.start  = held_one.start + 1'b1;
                    3:       r.body.length = held_one.length ^ ADDR_W'(1);
                    4:       r.body.client = random_client();
                    default: ;
                endcase
            end
        end else if (pick < 96) begin
            r.action = ACT_DISCONNECT;
            if (shadow.pick_held(held_one) && $urandom_range(0, 1) == 1)
                r.body.client = held_one.client;
        end else begin
            r.action = ACT_UNUSED;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        req_t r;
        int   burst_left;
        burst_left = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Shared read, then a zero-size write that still blocks a read over it
        issue(ACT_REGISTER, client_pool[0], ID_W'($urandom()), 48'd0, 48'd16, 1'b0);
        issue(ACT_REGISTER, client_pool[1], ID_W'($urandom()), 48'd16, 48'd0, 1'b1);
        issue(ACT_REGISTER, client_pool[1], ID_W'($urandom()), 48'd10, 48'd10, 1'b0);
        // Top of the offset space: sums must not wrap
        issue(ACT_REGISTER, client_pool[3], ID_W'($urandom()), ADDR_MAX, ADDR_MAX, 1'b0);
        issue(ACT_REGISTER, client_pool[3], ID_W'($urandom()), ADDR_MAX - 48'd15,
              48'd16, 1'b1);
        // Unregister with wrong mode misses, exact match hits
        issue(ACT_UNREGISTER, client_pool[0], ID_W'(1), 48'd0, 48'd16, 1'b1);
        issue(ACT_UNREGISTER, client_pool[0], ID_W'(1), 48'd0, 48'd16, 1'b0);
        // Disconnect of a client with nothing held, then the unused action
        issue(ACT_DISCONNECT, 32'hFFFF_FFFF, ID_W'($urandom()), wide_random(),
              wide_random(), 1'b1);
        issue(ACT_UNUSED, $urandom(), ID_W'($urandom()), wide_random(), wide_random(),
              1'b0);
        // Fill the table with overlapping shared reads
        for (int i = 0; i < DEPTH - 2; i++)
            issue(ACT_REGISTER, client_pool[2], ID_W'($urandom()), 48'd100 + i, 48'd50,
                  1'b0);
        // Full table: collision wins over full, then plain full
        issue(ACT_REGISTER, client_pool[0], ID_W'($urandom()), 48'd110, 48'd4, 1'b1);
        issue(ACT_REGISTER, client_pool[0], ID_W'($urandom()), 48'd5000, 48'd1, 1'b0);
        issue(ACT_DISCONNECT, client_pool[2], ID_W'($urandom()), 48'd0, 48'd0, 1'b0);

        // Random traffic in bursts, with one full drain halfway
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (burst_left == 0) begin
                if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 30));
                burst_left = $urandom_range(1, 12);
            end
            if (n == RANDOM_ITEMS / 2) drain_replies();
            make_random_request(r);
            send_request(r);
            burst_left--;
        end

        drain_replies();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (shadow.failures == 0 && shadow.outstanding() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
